// ===== sv/bab_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bab_pkg
// Shared types and constants of the block allocation bitmap.
// ----------------------------------------------------------------------------
package bab_pkg;

	localparam int MAX_BLOCKS = 256;
	localparam int ROW_W      = 32;
	localparam int ROWS       = MAX_BLOCKS / ROW_W;
	localparam int ROW_AW     = $clog2(ROWS);
	localparam int BIT_AW     = $clog2(ROW_W);
	localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
	localparam int CFG_W      = 9;
	localparam int FREE_W     = 16;

	localparam logic [7:0] USER_MAX = 8'h0F;

	localparam logic [1:0] REG_BLOCK_COUNT  = 2'd0;
	localparam logic [1:0] REG_DIR_BLOCKS   = 2'd1;
	localparam logic [1:0] REG_BLOCK_FACTOR = 2'd2;

	typedef enum logic [1:0] {
		MODE_REBUILD = 2'd0,
		MODE_RECORD  = 2'd1,
		MODE_ALLOC   = 2'd2,
		MODE_NONE    = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_ILLEGAL   = 2'd1,
		ST_DUPLICATE = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] user_code;
		logic [7:0] block_number;
	} cmd_t;

	typedef struct packed {
		logic [7:0]        block_out;
		logic [1:0]        status;
		logic [FREE_W-1:0] free_space;
	} rsp_t;

	typedef struct packed {
		logic load;
		logic rebuild_wr;
		logic rd;
		logic rec_upd;
		logic alloc_upd;
		logic row_inc;
		logic calc;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		mode_t mode;
		logic  last_row;
		logic  found;
		logic  out_busy;
	} dp_sts_t;

endpackage

`default_nettype wire

// ===== sv/bab_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bab_ctrl
// Sequencer that steps the datapath through rebuild, record and allocate.
// ----------------------------------------------------------------------------
module bab_ctrl import bab_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    cmd_valid,
	output logic         cmd_ready,
	input  wire dp_sts_t sts,
	output dp_cmd_t      ctl
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_REBUILD,
		S_READ,
		S_EVAL,
		S_CALC,
		S_RESP
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		ctl     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					ctl.load = 1'b1;
					state_d  = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				case (sts.mode)
					MODE_REBUILD: state_d = S_REBUILD;
					MODE_RECORD:  state_d = S_READ;
					MODE_ALLOC:   state_d = S_READ;
					default:      state_d = S_CALC;
				endcase
			end
			S_REBUILD: begin
				ctl.rebuild_wr = 1'b1;
				ctl.row_inc    = 1'b1;
				if (sts.last_row) begin
					state_d = S_CALC;
				end
			end
			S_READ: begin
				ctl.rd  = 1'b1;
				state_d = S_EVAL;
			end
			S_EVAL: begin
				if (sts.mode == MODE_RECORD) begin
					ctl.rec_upd = 1'b1;
					state_d     = S_CALC;
				end else begin
					ctl.alloc_upd = 1'b1;
					if (sts.found || sts.last_row) begin
						state_d = S_CALC;
					end else begin
						ctl.row_inc = 1'b1;
						state_d     = S_READ;
					end
				end
			end
			S_CALC: begin
				ctl.calc = 1'b1;
				state_d  = S_RESP;
			end
			S_RESP: begin
				if (!sts.out_busy) begin
					ctl.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign cmd_ready = (state_q == S_IDLE);

endmodule

`default_nettype wire

// ===== sv/bab_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bab_datapath
// Bitmap row memory, used-block count, configuration and result registers.
// ----------------------------------------------------------------------------
module bab_datapath import bab_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cmd_t             cmd,
	input  wire dp_cmd_t          ctl,
	output dp_sts_t               sts,
	input  wire logic             cfg_we,
	input  wire logic [1:0]       cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data,
	output logic                  rsp_valid,
	input  wire logic             rsp_ready,
	output rsp_t                  rsp
);

	logic [CNT_W-1:0]  block_count_q;
	logic [7:0]        dir_blocks_q;
	logic [7:0]        block_factor_q;

	mode_t             mode_q;
	logic [7:0]        user_q;
	logic [7:0]        blk_q;
	logic [ROW_AW-1:0] row_q;
	logic [CNT_W-1:0]  used_q;
	logic [7:0]        block_out_q;
	status_t           status_q;
	logic [FREE_W-1:0] free_q;

	logic [ROW_W-1:0]  map_q [ROWS];
	logic [ROWS-1:0]   row_vld_q;
	logic [ROW_W-1:0]  rd_data_q;
	logic              rd_ok_q;

	logic              rsp_vld_q;
	rsp_t              rsp_q;

	logic [CNT_W-1:0]  n_eff;
	logic [CNT_W-1:0]  d_eff;
	logic [ROW_W-1:0]  row_cur;
	logic [ROW_W-1:0]  dir_mask;
	logic [ROW_W-1:0]  elig;
	logic [BIT_AW-1:0] first_idx;
	logic              found;
	logic [ROW_AW-1:0] blk_row;
	logic [BIT_AW-1:0] blk_bit;
	logic              rec_skip;
	logic              rec_illegal;
	logic              rec_dup;
	logic              rec_wr;
	logic              alloc_wr;
	logic              mem_we;
	logic [ROW_AW-1:0] rd_addr;
	logic [ROW_AW-1:0] wr_addr;
	logic [ROW_W-1:0]  wr_data;
	logic [CNT_W-1:0]  free_blocks;
	logic [CNT_W+7:0]  product;

	assign n_eff = (block_count_q > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : block_count_q;
	assign d_eff = ({1'b0, dir_blocks_q} > n_eff) ? n_eff : {1'b0, dir_blocks_q};

	assign blk_row = blk_q[ROW_AW+BIT_AW-1:BIT_AW];
	assign blk_bit = blk_q[BIT_AW-1:0];
	assign row_cur = rd_ok_q ? rd_data_q : '0;

	always_comb begin
		for (int b = 0; b < ROW_W; b++) begin
			dir_mask[b] = ({row_q, BIT_AW'(b)} < d_eff);
			elig[b]     = !row_cur[b] && ({row_q, BIT_AW'(b)} < n_eff);
		end
	end

	always_comb begin
		first_idx = '0;
		for (int b = ROW_W - 1; b >= 0; b--) begin
			if (elig[b]) begin
				first_idx = BIT_AW'(b);
			end
		end
	end

	assign found = |elig;

	assign rec_skip    = (user_q > USER_MAX) || (blk_q == 8'd0);
	assign rec_illegal = ({1'b0, blk_q} >= n_eff);
	assign rec_dup     = row_cur[blk_bit];
	assign rec_wr      = ctl.rec_upd && !rec_skip && !rec_illegal && !rec_dup;
	assign alloc_wr    = ctl.alloc_upd && found;
	assign mem_we      = ctl.rebuild_wr || rec_wr || alloc_wr;

	assign rd_addr = (mode_q == MODE_RECORD) ? blk_row : row_q;
	assign wr_addr = rd_addr;

	always_comb begin
		if (ctl.rebuild_wr) begin
			wr_data = dir_mask;
		end else if (ctl.rec_upd) begin
			wr_data = row_cur | (ROW_W'(1) << blk_bit);
		end else begin
			wr_data = row_cur | (ROW_W'(1) << first_idx);
		end
	end

	assign free_blocks = (n_eff > used_q) ? (n_eff - used_q) : '0;
	assign product     = free_blocks * block_factor_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			map_q[wr_addr] <= wr_data;
		end
		if (ctl.rd) begin
			rd_data_q <= map_q[rd_addr];
			rd_ok_q   <= row_vld_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q      <= '0;
			used_q         <= '0;
			block_count_q  <= CNT_W'(MAX_BLOCKS);
			dir_blocks_q   <= 8'd2;
			block_factor_q <= 8'd8;
			rsp_vld_q      <= 1'b0;
		end else begin
			if (mem_we) begin
				row_vld_q[wr_addr] <= 1'b1;
			end
			if (ctl.rebuild_wr) begin
				used_q <= d_eff;
			end else if (rec_wr || alloc_wr) begin
				used_q <= used_q + CNT_W'(1);
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_BLOCK_COUNT:  block_count_q  <= cfg_data[CNT_W-1:0];
					REG_DIR_BLOCKS:   dir_blocks_q   <= cfg_data[7:0];
					REG_BLOCK_FACTOR: block_factor_q <= cfg_data[7:0];
					default: ;
				endcase
			end
			if (ctl.out_load) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			mode_q      <= mode_t'(cmd.mode);
			user_q      <= cmd.user_code;
			blk_q       <= cmd.block_number;
			row_q       <= '0;
			block_out_q <= '0;
			status_q    <= ST_OK;
		end else begin
			if (ctl.row_inc) begin
				row_q <= row_q + ROW_AW'(1);
			end
			if (ctl.rec_upd && !rec_skip) begin
				if (rec_illegal) begin
					status_q <= ST_ILLEGAL;
				end else if (rec_dup) begin
					status_q <= ST_DUPLICATE;
				end
			end
			if (alloc_wr) begin
				block_out_q <= {row_q, first_idx};
			end else if (ctl.alloc_upd && sts.last_row) begin
				status_q <= ST_FULL;
			end
		end
		if (ctl.calc) begin
			free_q <= (product > (CNT_W+8)'(16'hFFFF)) ? 16'hFFFF : product[FREE_W-1:0];
		end
		if (ctl.out_load) begin
			rsp_q.block_out  <= block_out_q;
			rsp_q.status     <= status_q;
			rsp_q.free_space <= free_q;
		end
	end

	assign sts.mode     = mode_q;
	assign sts.last_row = (row_q == ROW_AW'(ROWS - 1));
	assign sts.found    = found;
	assign sts.out_busy = rsp_vld_q && !rsp_ready;

	assign rsp_valid = rsp_vld_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

// ===== sv/block_allocation_bitmap.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// block_allocation_bitmap
// One-bit-per-block allocation map with used-block count and free space.
//
//   channel | signals                        | moves
//   cmd     | cmd_valid, cmd_ready, cmd      | one operation request
//   rsp     | rsp_valid, rsp_ready, rsp      | one result per request
//   cfg     | cfg_we, cfg_index, cfg_data    | register write, no wait
//
// Rebuild writes every 32-block row, record reads and evaluates one row,
// allocate reads and evaluates rows until a free block or the last row,
// an unknown mode skips the map; all then compute free space and respond.
// The map lives in a 32-bit-wide row memory. Reset marks all rows invalid
// (all free) at once. A held result stalls the next result and the next acceptance.
// ----------------------------------------------------------------------------
module block_allocation_bitmap import bab_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cmd_valid,
	output logic                  cmd_ready,
	input  wire cmd_t             cmd,
	output logic                  rsp_valid,
	input  wire logic             rsp_ready,
	output rsp_t                  rsp,
	input  wire logic             cfg_we,
	input  wire logic [1:0]       cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data
);

	dp_cmd_t ctl;
	dp_sts_t sts;

	bab_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	bab_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.ctl       (ctl),
		.sts       (sts),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	a_full_no_block: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status == ST_FULL) |-> (rsp.block_out == 8'd0))
		else $error("full result carries a block number");

	a_one_map_update: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctl.rebuild_wr, ctl.rec_upd, ctl.alloc_upd}))
		else $error("more than one map update at once");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && cmd_ready) |=> !cmd_ready)
		else $error("second transaction accepted while busy");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.out_load |-> !sts.out_busy)
		else $error("result register overwritten while held");

endmodule

`default_nettype wire
